>>> design/gost_pkg.sv
// Shared types, constants and round functions for the GOST 28147-89 cipher core.
// Used by the interfaces, the round stage and the top level; no dependencies.
package gost_pkg;

  localparam int NumRounds = 32;
  localparam int NumCfgRegs = 4;
  localparam int CfgIdxWidth = 2;
  localparam int RotAmount = 11;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [CfgIdxWidth-1:0] REG_KEY_0_1 = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_2_3 = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_4_5 = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_KEY_6_7 = 2'd3;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] key_words_t;
  typedef logic [NumCfgRegs-1:0][63:0] key_regs_t;

  typedef struct packed {
    logic  op;
    word_t n1;
    word_t n2;
  } gost_blk_t;

  // Row i is applied to nibble i, counting from the lowest nibble.
  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7}
  };

  // Substitution followed by a rotation left by eleven bits.
  function automatic word_t round_f(input word_t v);
    word_t s;
    for (int i = 0; i < 8; i++) begin
      s[4*i +: 4] = SBOX[i][v[4*i +: 4]];
    end
    return {s[31-RotAmount:0], s[31:32-RotAmount]};
  endfunction

  // Key word used in a given round for the selected direction.
  function automatic logic [2:0] key_index(input logic [4:0] rnd, input logic op);
    logic [1:0] pass;
    logic [2:0] pos;
    logic       forward;
    pass = rnd[4:3];
    pos = rnd[2:0];
    if (op == OP_DECRYPT) begin
      forward = (pass == 2'd0);
    end else begin
      forward = (pass != 2'd3);
    end
    return forward ? pos : 3'd7 - pos;
  endfunction

endpackage

>>> design/gost_if.sv
// Handshake channel interfaces for the block input, result output and key port.
// Depends on gost_pkg for the word and index widths.
interface gost_in_if import gost_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  op;
  word_t block_low;
  word_t block_high;

  modport source (output valid, output op, output block_low, output block_high,
                  input ready);
  modport sink (input valid, input op, input block_low, input block_high,
                output ready);
endinterface

interface gost_out_if import gost_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t result_low;
  word_t result_high;

  modport source (output valid, output result_low, output result_high,
                  input ready);
  modport sink (input valid, input result_low, input result_high,
                output ready);
endinterface

interface gost_cfg_if import gost_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [63:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/gost_round.sv
// One registered Feistel round of the cipher pipeline with its own valid bit.
// Depends on gost_pkg for the block type, S-boxes and key schedule.
module gost_round import gost_pkg::*; #(
  parameter int ROUND = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  gost_blk_t  up_blk,
  output logic       down_valid,
  input  logic       down_ready,
  output gost_blk_t  down_blk,
  input  key_words_t key_words
);

  localparam logic [4:0] RND = 5'(ROUND);

  logic      valid;
  gost_blk_t blk;
  gost_blk_t blk_next;
  word_t     key_word;

  assign up_ready = !valid || down_ready;
  assign key_word = key_words[key_index(RND, up_blk.op)];

  always_comb begin
    blk_next = up_blk;
    if (RND[0] == 1'b0) begin
      blk_next.n2 = up_blk.n2 ^ round_f(up_blk.n1 + key_word);
    end else begin
      blk_next.n1 = up_blk.n1 ^ round_f(up_blk.n2 + key_word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk <= blk_next;
    end
  end

  assign down_valid = valid;
  assign down_blk = blk;

endmodule

>>> design/gost_block_cipher_core.sv
// GOST 28147-89 block cipher core: 32 registered rounds, one round per stage.
// Each block passes through the registered round stages in order; one block is
// accepted per cycle while the result side keeps taking items.
// Each stage holds its item under a stall and frees when it moves on.
// Synchronous active-high reset empties the pipeline and clears the key to zero.
// Depends on gost_pkg, gost_if and gost_round.
module gost_block_cipher_core import gost_pkg::*; (
  input logic       clk,
  input logic       rst,
  gost_in_if.sink   blk_in,
  gost_out_if.source blk_out,
  gost_cfg_if.sink  cfg
);

  key_regs_t  key_reg;
  key_words_t key_words;

  logic      stage_valid [0:NumRounds];
  logic      stage_ready [0:NumRounds];
  gost_blk_t stage_blk   [0:NumRounds];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_KEY_0_1: key_reg[0] <= cfg.data;
        REG_KEY_2_3: key_reg[1] <= cfg.data;
        REG_KEY_4_5: key_reg[2] <= cfg.data;
        REG_KEY_6_7: key_reg[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign key_words = key_words_t'(key_reg);

  assign stage_valid[0] = blk_in.valid;
  assign blk_in.ready = stage_ready[0];
  assign stage_blk[0] = '{op: blk_in.op, n1: blk_in.block_low, n2: blk_in.block_high};

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    gost_round #(.ROUND(r)) u_round (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stage_valid[r]),
      .up_ready   (stage_ready[r]),
      .up_blk     (stage_blk[r]),
      .down_valid (stage_valid[r+1]),
      .down_ready (stage_ready[r+1]),
      .down_blk   (stage_blk[r+1]),
      .key_words  (key_words)
    );
  end

  assign stage_ready[NumRounds] = blk_out.ready;
  assign blk_out.valid = stage_valid[NumRounds];
  assign blk_out.result_low = stage_blk[NumRounds].n2;
  assign blk_out.result_high = stage_blk[NumRounds].n1;

`ifndef ASSERT_OFF
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !blk_in.ready |-> (blk_out.valid && !blk_out.ready))
    else $error("input stalled while the pipeline has a free stage");

  a_last_round_advances: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[NumRounds-1] && (blk_out.ready || !blk_out.valid)) |=> blk_out.valid)
    else $error("item in the last round did not reach the output");
`endif

endmodule
